// File: hw/rtl/lba_pkg.sv
// Shared types and constants for the linked block allocator.
// Used by lba_ctrl, lba_datapath and linked_block_allocator; no dependencies.
package lba_pkg;

  localparam int BLK_W      = 6;   // block number field
  localparam int CNT_W      = 7;   // counts and scan pointer, hold 0..64
  localparam int LINK_W     = 7;   // signed link, all ones is end of chain
  localparam int BLK_SPAN   = 64;  // reach of the block number field
  localparam int ST_W       = 2;

  localparam logic [ST_W-1:0] ST_ALLOC   = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
  localparam logic [ST_W-1:0] ST_READ    = 2'd3;

  localparam logic [LINK_W-1:0] END_LINK = 7'h7F;

  // controller -> datapath
  typedef struct packed {
    logic            load_req;    // capture the accepted item
    logic            scan_clr;    // pointer and count back to zero
    logic            count_step;  // free-block counting pass, one block
    logic            pick_step;   // allocation pass, one block
    logic            tail_emit;   // emit the final block of the chain
    logic            rd_issue;    // read the link memory at the request index
    logic            rsp_emit;    // emit a single-result response
    logic [ST_W-1:0] rsp_status;
  } lba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_read;
    logic size_zero;
    logic idx_bad;
    logic ptr_end;
    logic cur_free;
    logic cnt_zero;
    logic cnt_full;
    logic last_pick;
    logic slot_free;
  } lba_stat_t;

endpackage

// File: hw/rtl/lba_ctrl.sv
// Sequencer for the linked block allocator: decode, count pass, pick pass, responses.
// Depends on lba_pkg for the command and status structs and status codes.
module lba_ctrl
  import lba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lba_stat_t stat,
  output lba_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_FAIL  = 3'd5;
  localparam logic [2:0] S_INVAL = 3'd6;
  localparam logic [2:0] S_RDOUT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op_read) begin
          if (stat.idx_bad) begin
            state_nxt = S_INVAL;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_RDOUT;
          end
        end else if (stat.size_zero) begin
          state_nxt = S_INVAL;
        end else begin
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        // stop as soon as enough free blocks are seen
        if (stat.cnt_full) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_PICK;
        end else if (stat.ptr_end) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.count_step = 1'b1;
        end
      end
      S_PICK: begin
        // hold while a chained result cannot be placed
        if (!stat.cur_free || stat.cnt_zero || stat.slot_free) begin
          cmd.pick_step = 1'b1;
          if (stat.last_pick) state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        if (stat.slot_free) begin
          cmd.tail_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FAIL: begin
        if (stat.slot_free) begin
          cmd.rsp_emit   = 1'b1;
          cmd.rsp_status = ST_NOSPACE;
          state_nxt      = S_IDLE;
        end
      end
      S_INVAL: begin
        if (stat.slot_free) begin
          cmd.rsp_emit   = 1'b1;
          cmd.rsp_status = ST_INVALID;
          state_nxt      = S_IDLE;
        end
      end
      S_RDOUT: begin
        if (stat.slot_free) begin
          cmd.rsp_emit   = 1'b1;
          cmd.rsp_status = ST_READ;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/lba_datapath.sv
// Datapath of the linked block allocator: occupied bits, link memory, scan
// pointer and counters, block-count register and the output register.
// Depends on lba_pkg; driven by lba_ctrl through lba_cmd_t.
module lba_datapath
  import lba_pkg::*;
#(
  parameter int NUM_BLOCKS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lba_cmd_t          cmd,
  output lba_stat_t         stat,
  input  logic              in_opcode,
  input  logic [CNT_W-1:0]  in_file_size,
  input  logic [BLK_W-1:0]  in_block_index,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic [BLK_W-1:0]  out_block,
  output logic              out_occupied,
  output logic [LINK_W-1:0] out_next_block,
  output logic              out_last
);

  // blocks past the 6-bit block field are never reachable
  localparam int DEPTH = (NUM_BLOCKS < BLK_SPAN) ? NUM_BLOCKS : BLK_SPAN;
  localparam int IDX_W = $clog2(DEPTH);

  logic [CNT_W-1:0]  disk_cnt_r;
  logic [CNT_W-1:0]  usable;

  logic              op_r;
  logic [CNT_W-1:0]  size_r;
  logic [BLK_W-1:0]  idx_r;

  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BLK_W-1:0]  prev_r, prev_nxt;
  logic [DEPTH-1:0]  occ_r, occ_nxt;

  logic [LINK_W-1:0] link_mem [DEPTH];
  logic [LINK_W-1:0] rd_link_r;
  logic              lnk_we;
  logic [LINK_W-1:0] lnk_wdata;

  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [BLK_W-1:0]  out_block_r, out_block_nxt;
  logic              out_occ_r, out_occ_nxt;
  logic [LINK_W-1:0] out_next_r, out_next_nxt;
  logic              out_last_r, out_last_nxt;

  logic              cur_free;
  logic              emit;
  logic [CNT_W:0]    cnt_inc;

  assign usable   = (disk_cnt_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : disk_cnt_r;
  assign cur_free = !occ_r[ptr_r[IDX_W-1:0]];
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;

  assign stat.op_read   = op_r;
  assign stat.size_zero = (size_r == '0);
  assign stat.idx_bad   = ({1'b0, idx_r} >= usable);
  assign stat.ptr_end   = (ptr_r >= usable);
  assign stat.cur_free  = cur_free;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.cnt_full  = (cnt_r == size_r);
  assign stat.last_pick = cur_free && (cnt_inc == {1'b0, size_r});
  assign stat.slot_free = !out_valid_r || out_ready;

  assign emit      = (cmd.pick_step && cur_free && (cnt_r != '0)) || cmd.tail_emit
                     || cmd.rsp_emit;
  assign lnk_we    = (cmd.pick_step && cur_free && (cnt_r != '0)) || cmd.tail_emit;
  assign lnk_wdata = cmd.tail_emit ? END_LINK : {1'b0, ptr_r[BLK_W-1:0]};

  always_comb begin
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    prev_nxt       = prev_r;
    occ_nxt        = occ_r;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_occ_nxt    = out_occ_r;
    out_next_nxt   = out_next_r;
    out_last_nxt   = out_last_r;

    if (cmd.scan_clr) begin
      ptr_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.count_step) begin
      ptr_nxt = ptr_r + 1'b1;
      if (cur_free) cnt_nxt = cnt_inc[CNT_W-1:0];
    end
    if (cmd.pick_step) begin
      ptr_nxt = ptr_r + 1'b1;
      if (cur_free) begin
        cnt_nxt                      = cnt_inc[CNT_W-1:0];
        prev_nxt                     = ptr_r[BLK_W-1:0];
        occ_nxt[ptr_r[IDX_W-1:0]]    = 1'b1;
        // previous pick now knows its successor; the first pick has none yet
        if (cnt_r != '0) begin
          out_status_nxt = ST_ALLOC;
          out_block_nxt  = prev_r;
          out_occ_nxt    = 1'b1;
          out_next_nxt   = {1'b0, ptr_r[BLK_W-1:0]};
          out_last_nxt   = 1'b0;
        end
      end
    end
    if (cmd.tail_emit) begin
      out_status_nxt = ST_ALLOC;
      out_block_nxt  = prev_r;
      out_occ_nxt    = 1'b1;
      out_next_nxt   = END_LINK;
      out_last_nxt   = 1'b1;
    end
    if (cmd.rsp_emit) begin
      out_status_nxt = cmd.rsp_status;
      out_block_nxt  = '0;
      out_occ_nxt    = 1'b0;
      out_next_nxt   = END_LINK;
      out_last_nxt   = 1'b1;
      if (cmd.rsp_status == ST_READ) begin
        out_block_nxt = idx_r;
        if (occ_r[idx_r[IDX_W-1:0]]) begin
          out_occ_nxt  = 1'b1;
          out_next_nxt = rd_link_r;
        end
      end
    end

    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_cnt_r  <= CNT_W'(BLK_SPAN);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) disk_cnt_r <= cfg_data;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r   <= in_opcode;
      size_r <= in_file_size;
      idx_r  <= in_block_index;
    end
    prev_r       <= prev_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_occ_r    <= out_occ_nxt;
    out_next_r   <= out_next_nxt;
    out_last_r   <= out_last_nxt;
  end

  // links are only read for occupied blocks, so the memory needs no reset
  always_ff @(posedge clk) begin
    if (lnk_we) link_mem[prev_r[IDX_W-1:0]] <= lnk_wdata;
    if (cmd.rd_issue) rd_link_r <= link_mem[idx_r[IDX_W-1:0]];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block      = out_block_r;
  assign out_occupied   = out_occ_r;
  assign out_next_block = out_next_r;
  assign out_last       = out_last_r;

endmodule

// File: hw/rtl/linked_block_allocator.sv
// Linked block allocator: occupied bitmap plus next-block link table.
// Request channel in_*, result channel out_*, both valid/ready; one config
// register, the usable block count, written through cfg_we / cfg_data.
// An allocate item (opcode 0) takes the lowest free blocks up to file_size,
// marks and chains them, and returns one result per block (status 0, block,
// successor or -1, last on the final one). Too few free blocks gives one
// status 1 result; a zero size gives one status 2 result; state is untouched.
// A read item (opcode 1) returns one block's occupied bit and link (status 3),
// or status 2 when the index is at or beyond the usable count.
// The user must write the config register only while idle; the block does
// not enforce this. One item at a time. A read or a zero size goes through
// the check state to the read-out or invalid state, which loads its result.
// An allocate makes a counting pass over the blocks, one block per cycle,
// then a pick pass at one block per cycle emitting each chained block as its
// successor is found, and the final block after the last pick. Too few free
// blocks gives its result when the counting pass reaches the usable count.
// Results sit in an output register; a new item is accepted the cycle after
// the final result is loaded, while that result waits. A stalled receiver
// holds the pick pass in place; the scan pointer restarts at block 0 for it.
// Reset (rst_n low, synchronous) frees every block and sets the block count to 64.
module linked_block_allocator
  import lba_pkg::*;
#(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  logic [CNT_W-1:0]         in_file_size,
  input  logic [BLK_W-1:0]         in_block_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ST_W-1:0]          out_status,
  output logic [BLK_W-1:0]         out_block,
  output logic                     out_occupied,
  output logic signed [LINK_W-1:0] out_next_block,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_data
);

  lba_cmd_t          cmd;
  lba_stat_t         stat;
  logic [LINK_W-1:0] next_raw;

  lba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_opcode),
    .in_file_size   (in_file_size),
    .in_block_index (in_block_index),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_block      (out_block),
    .out_occupied   (out_occupied),
    .out_next_block (next_raw),
    .out_last       (out_last)
  );

  assign out_next_block = $signed(next_raw);

endmodule
